>>> rtl/core/stir_pkg.sv
// shared types and constants of the sorted table core
package stir_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 6;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int DEPTH_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // what one cell hands to the next one up
    typedef struct packed {
        logic              keep;
        logic [DATA_W-1:0] entry;
    } t_link;

    // request broadcast to every cell
    typedef struct packed {
        logic              ins_en;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  position;
    } t_cell_ctl;

endpackage

>>> rtl/core/stir_cell.sv
// one table cell: holds one entry and shifts it up or down on insert and remove
module stir_cell
    import stir_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_rem_en,
    input  logic [CNT_W-1:0]  i_count,
    input  t_link             i_prev,
    input  logic [DATA_W-1:0] i_next_entry,
    output t_link             o_link,
    output logic              o_hit,
    output logic              o_rd_hit,
    output logic [DATA_W-1:0] o_rd_value
);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic              valid;
    logic              less;
    logic              keep;

    assign valid = int'(i_count) > IDX;
    assign less  = $signed(r_entry) < $signed(i_ctl.value);
    assign keep  = valid && less;

    assign o_link = '{keep: keep, entry: r_entry};

    // first entry not below the value sits right above the last kept cell
    assign o_hit = valid && !less && i_prev.keep && (r_entry == i_ctl.value);

    assign o_rd_hit   = valid && (int'(i_ctl.position) == IDX);
    assign o_rd_value = o_rd_hit ? r_entry : '0;

    always_comb begin
        priority if (i_ctl.ins_en) begin
            if (keep) begin
                n_entry = r_entry;
            end else if (i_prev.keep) begin
                n_entry = i_ctl.value;
            end else begin
                n_entry = i_prev.entry;
            end
        end else if (i_rem_en) begin
            n_entry = keep ? r_entry : i_next_entry;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> rtl/core/sorted_table_insert_remove_core.sv
// Sorted table of signed 32-bit entries held in a row of TABLE_DEPTH cells, one entry per
// cell. Every cell compares its entry with the request value at the same time; an insert
// shifts the entries above the insertion point up by one cell, a remove shifts the entries
// above the first match down by one cell, and a read picks the cell at the requested
// position. Each request is done in the cycle of its transfer, which also loads its result
// into an output register, so the core takes one request per clock as long as the result
// side keeps up. No clearing pass after reset: cells above the count are never read.
module sorted_table_insert_remove_core
    import stir_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1),
    localparam int IN_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // value, position
    input  logic [OP_W-1:0]        s_axis_tuser,  // opcode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // read_value, entry_count
    output logic [ST_W-1:0]        m_axis_tuser   // status
);

    logic              accept;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              full;
    logic              found;
    logic              rem_en;
    logic              rd_ok;
    logic [DATA_W-1:0] rd_value;
    t_cell_ctl         ctl;

    t_link                  w_link [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] w_rd_hit;
    logic [DATA_W-1:0]      w_rd_val [TABLE_DEPTH];

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_m_valid;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] n_rd;

    assign op       = s_axis_tuser;
    assign value    = s_axis_tdata[DATA_W-1:0];
    assign position = s_axis_tdata[DATA_W +: POS_W];

    assign s_axis_tready = i_rst_n && (!r_m_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = r_count == CNT_W'(TABLE_DEPTH);

    assign ctl.ins_en   = accept && (op == OP_INSERT) && !full;
    assign ctl.value    = value;
    assign ctl.position = position;
    assign rem_en       = accept && (op == OP_REMOVE) && found;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_link             prev;
        logic [DATA_W-1:0] next_entry;

        if (g == 0) begin : g_first
            assign prev = '{keep: 1'b1, entry: '0};
        end else begin : g_inner
            assign prev = w_link[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_top
            assign next_entry = '0;
        end else begin : g_below
            assign next_entry = w_link[g+1].entry;
        end

        stir_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_rem_en     (rem_en),
            .i_count      (r_count),
            .i_prev       (prev),
            .i_next_entry (next_entry),
            .o_link       (w_link[g]),
            .o_hit        (w_hit[g]),
            .o_rd_hit     (w_rd_hit[g]),
            .o_rd_value   (w_rd_val[g])
        );
    end

    assign found = |w_hit;
    assign rd_ok = |w_rd_hit;

    always_comb begin
        rd_value = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            rd_value = rd_value | w_rd_val[i];
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_rd     = '0;
        unique case (op)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_READ: begin
                if (rd_ok) begin
                    n_rd = rd_value;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_rd     <= n_rd;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_count, r_rd});
    assign m_axis_tuser  = r_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= TABLE_DEPTH)
        else $error("entry count above table depth");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell claims the first match");

    a_single_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_rd_hit))
        else $error("more than one cell selected for read");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins_en |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the count");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("no result after request transfer");
`endif

endmodule

>>> tb/tb.sv
// self-checking testbench for the sorted table core: directed and random insert, remove, read
module tb;
    import stir_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IN_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 750;
    localparam int LONG_HOLD    = 400;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int SEG_FILL  = 0;
    localparam int SEG_DRAIN = 1;
    localparam int SEG_MIXED = 2;

    typedef struct {
        t_status            status;
        logic [DATA_W-1:0]  read_value;
        logic [CNT_W-1:0]   entry_count;
    } t_table_result;

    // mirror of the sorted table plus the results still owed by the core
    class table_scoreboard;
        logic signed [DATA_W-1:0] entries[$];
        t_table_result            owed_q[$];
        int                       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function logic signed [DATA_W-1:0] any_entry();
            return entries[$urandom_range(0, entries.size() - 1)];
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            t_table_result r;
            int at;
            r.status     = ST_OK;
            r.read_value = '0;
            at = 0;
            case (op)
                OP_INSERT: begin
                    if (entries.size() >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // an equal value goes in ahead of the entries equal to it
                        while (at < entries.size() && entries[at] < value)
                            at++;
                        entries.insert(at, value);
                    end
                end
                OP_REMOVE: begin
                    while (at < entries.size() && entries[at] != value)
                        at++;
                    if (at >= entries.size())
                        r.status = ST_NOT_FOUND;
                    else
                        entries.delete(at);
                end
                OP_READ: begin
                    if (pos < entries.size())
                        r.read_value = entries[pos];
                    else
                        r.status = ST_RANGE;
                end
                default: ;
            endcase
            r.entry_count = CNT_W'(entries.size());
            owed_q.push_back(r);
        endfunction

        function void check_result(logic [ST_W-1:0] status, logic [DATA_W-1:0] read_value,
                                   logic [CNT_W-1:0] entry_count);
            t_table_result e;
            if (owed_q.size() == 0) begin
                flag($sformatf("result with nothing pending: status %0d value %h count %0d",
                               status, read_value, entry_count));
                return;
            end
            e = owed_q.pop_front();
            if (status !== e.status)
                flag($sformatf("status exp %0d got %0d", e.status, status));
            if (read_value !== e.read_value)
                flag($sformatf("read_value exp %h got %h", e.read_value, read_value));
            if (entry_count !== e.entry_count)
                flag($sformatf("entry_count exp %0d got %0d", e.entry_count, entry_count));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // value, position
    logic [OP_W-1:0]        s_axis_tuser = OP_INSERT;  // opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // read_value, entry_count
    logic [ST_W-1:0]        m_axis_tuser;        // status

    table_scoreboard sb = new();
    bit send_no_gap   = 1'b0;
    bit recv_no_stall = 1'b0;
    bit long_hold_req = 1'b0;

    sorted_table_insert_remove_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = send_no_gap ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - DATA_W - POS_W){1'b0}}, pos, value};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, value, pos);
    endtask

    function automatic logic signed [DATA_W-1:0] draw_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $signed($urandom_range(0, 15)) - 8;   // narrow pool for duplicates
        else if (pick == 5)
            return {1'b1, {(DATA_W-1){1'b0}}};
        else if (pick == 6)
            return {1'b0, {(DATA_W-1){1'b1}}};
        else
            return $urandom();
    endfunction

    // result side: random stalls, plus one long hold-off when asked
    initial begin : result_side
        int stall;
        stall = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                stall = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_result(m_axis_tuser, m_axis_tdata[DATA_W-1:0],
                            m_axis_tdata[DATA_W +: CNT_W]);
            stall = recv_no_stall ? 0 : $urandom_range(0, 13);
        end
    end

    initial begin : request_side
        int sent;
        int seg_kind;
        int seg_len;
        int roll;
        int i;
        bit first_seg;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table corners
        send_request(OP_READ,   32'sd0, 6'd0);
        send_request(OP_REMOVE, 32'sd5, 6'd0);
        // extremes and a duplicate
        send_request(OP_INSERT, 32'sd0, 6'd0);
        send_request(OP_INSERT, {1'b0, {(DATA_W-1){1'b1}}}, 6'd0);
        send_request(OP_INSERT, {1'b1, {(DATA_W-1){1'b0}}}, 6'd0);
        send_request(OP_INSERT, -32'sd1, 6'd63);
        send_request(OP_INSERT, 32'sd0, 6'd0);
        send_request(OP_READ,   32'sd0, 6'd0);
        send_request(OP_READ,   32'sd0, 6'd4);
        send_request(OP_READ,   32'sd0, 6'd2);
        send_request(OP_READ,   32'sd0, 6'd5);
        send_request(OP_READ,   32'sd0, 6'd63);
        // first of two equal entries goes, then an absent value
        send_request(OP_REMOVE, 32'sd0, 6'd0);
        send_request(OP_REMOVE, 32'sd12345, 6'd0);
        send_request(OP_UNUSED, 32'sd77, 6'd7);
        send_request(OP_INSERT, {1'b0, {(DATA_W-1){1'b1}}}, 6'd0);
        send_request(OP_REMOVE, {1'b0, {(DATA_W-1){1'b1}}}, 6'd0);
        send_request(OP_REMOVE, {1'b1, {(DATA_W-1){1'b0}}}, 6'd0);
        send_request(OP_READ,   32'sd0, 6'd1);
        send_request(OP_READ,   32'sd0, 6'd2);
        send_request(OP_UNUSED, -32'sd1, 6'd63);

        sent = 0;
        first_seg = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            seg_kind = first_seg ? SEG_FILL : $urandom_range(SEG_FILL, SEG_MIXED);
            seg_len  = first_seg ? 100 : $urandom_range(20, 90);
            send_no_gap   = first_seg ? 1'b1 : ($urandom_range(0, 3) == 0);
            recv_no_stall = ($urandom_range(0, 3) == 0);
            // receiver stops while back-to-back requests pile up behind it
            if (first_seg)
                long_hold_req = 1'b1;
            first_seg = 1'b0;
            for (i = 0; i < seg_len; i++) begin
                roll = $urandom_range(0, 99);
                case (seg_kind)
                    SEG_FILL:  op = (roll < 80) ? OP_INSERT : (roll < 88) ? OP_REMOVE : OP_READ;
                    SEG_DRAIN: op = (roll < 15) ? OP_INSERT : (roll < 80) ? OP_REMOVE : OP_READ;
                    default:   op = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_REMOVE : OP_READ;
                endcase
                value = draw_value();
                pos   = POS_W'($urandom_range(0, 63));
                if (op == OP_REMOVE && sb.entries.size() > 0 && $urandom_range(0, 99) < 75)
                    value = sb.any_entry();
                if (op == OP_READ && sb.entries.size() > 0 && $urandom_range(0, 99) < 80)
                    pos = POS_W'($urandom_range(0, sb.entries.size() - 1));
                send_request(op, value, pos);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
